// File: hw/rtl/aop_pkg.sv
// shared constants, types and arctangent table for the polarization angle pipeline
package aop_pkg;

    // sample and difference widths
    localparam int SAMPLE_BITS = 8;
    localparam int DIFF_BITS   = SAMPLE_BITS + 1;
    localparam int MAG_BITS    = SAMPLE_BITS;
    localparam int MSB_BITS    = (MAG_BITS > 1) ? $clog2(MAG_BITS) : 1;

    // normalization: larger component lands in [2^NORM_MSB, 2^(NORM_MSB+1))
    localparam int NORM_MSB   = 54;
    localparam int NORM_BITS  = NORM_MSB + 1;
    localparam int SHIFT_BITS = $clog2(NORM_MSB + 1);

    // cordic datapath
    localparam int CORDIC_STEPS  = 58;
    localparam int STEP_IDX_BITS = $clog2(CORDIC_STEPS);
    localparam int XY_BITS       = NORM_BITS + 4;
    localparam int Z_BITS        = 64;
    localparam int FRAC_BITS     = 62;

    // scaling: floor(28.662 * phi) = floor(((phi_q44 * 28662) >> 44) / 1000)
    localparam int Q44_SHIFT   = 18;
    localparam int Q44_BITS    = Z_BITS - 1 - Q44_SHIFT;
    localparam int SCALE_BITS  = 15;
    localparam logic [SCALE_BITS-1:0] SCALE_NUM = 15'd28662;
    localparam int PROD_BITS   = Q44_BITS + SCALE_BITS;
    localparam int PROD_SHIFT  = 44;
    localparam int V_BITS      = PROD_BITS - PROD_SHIFT;
    // exact floor(v / 1000) for any v below 2^V_BITS
    localparam int RECIP_BITS  = 17;
    localparam logic [RECIP_BITS-1:0] RECIP_1000 = 17'd67109;
    localparam int RECIP_SHIFT = 26;
    localparam int RPROD_BITS  = V_BITS + RECIP_BITS;
    localparam int M_BITS      = RPROD_BITS - RECIP_SHIFT;

    // result angles
    localparam int ANGLE_BITS = 8;
    localparam logic [ANGLE_BITS-1:0] ANG_UNDEF        = 8'd0;
    localparam logic [ANGLE_BITS-1:0] ANG_VERT_POS     = 8'd45;
    localparam logic [ANGLE_BITS-1:0] ANG_VERT_NEG     = 8'd134;
    localparam logic [ANGLE_BITS-1:0] ANG_HORIZ_POS    = 8'd180;
    localparam logic [ANGLE_BITS-1:0] ANG_HORIZ_NEG    = 8'd90;
    localparam logic [ANGLE_BITS-1:0] ANG_FOURTH_BASE  = 8'd179;
    localparam logic [ANGLE_BITS-1:0] ANG_THIRD_BASE   = 8'd90;
    localparam logic [ANGLE_BITS-1:0] ANG_SECOND_BASE  = 8'd89;

    // sign and zero flags of the two stokes differences
    typedef struct packed {
        logic s1_zero;
        logic s1_neg;
        logic s2_zero;
        logic s2_neg;
    } aop_side_t;

    typedef logic [CORDIC_STEPS-1:0][Z_BITS-1:0] aop_atan_tab_t;

    // atan(2^-sh) in q62 by alternating series, truncated terms
    function automatic logic [Z_BITS-1:0] atan_pow2(input int sh);
        logic [Z_BITS-1:0] p;
        logic [Z_BITS-1:0] s;
        logic [Z_BITS-1:0] term;
        int n;
        p = Z_BITS'(1) << (FRAC_BITS - sh);
        s = '0;
        n = 0;
        while (p != 0) begin
            term = p / Z_BITS'(2 * n + 1);
            if ((n % 2) == 0) begin
                s = s + term;
            end else begin
                s = s - term;
            end
            p = p >> (2 * sh);
            n = n + 1;
        end
        return s;
    endfunction

    // atan(1/3) in q62 by alternating series
    function automatic logic [Z_BITS-1:0] atan_third();
        logic [Z_BITS-1:0] p;
        logic [Z_BITS-1:0] s;
        logic [Z_BITS-1:0] term;
        int n;
        p = (Z_BITS'(1) << FRAC_BITS) / 3;
        s = '0;
        n = 0;
        while (p != 0) begin
            term = p / Z_BITS'(2 * n + 1);
            if ((n % 2) == 0) begin
                s = s + term;
            end else begin
                s = s - term;
            end
            p = (p / 3) / 3;
            n = n + 1;
        end
        return s;
    endfunction

    function automatic aop_atan_tab_t build_atan_tab();
        aop_atan_tab_t t;
        t[0] = atan_pow2(1) + atan_third();
        for (int i = 1; i < CORDIC_STEPS; i++) begin
            t[i] = atan_pow2(i);
        end
        return t;
    endfunction

    localparam aop_atan_tab_t ATAN_TAB = build_atan_tab();

endpackage

// File: hw/rtl/aop_front.sv
// front end: stokes differences, magnitudes and normalization of the vector
module aop_front (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic [aop_pkg::SAMPLE_BITS-1:0]      sample_0deg,
    input  logic [aop_pkg::SAMPLE_BITS-1:0]      sample_45deg,
    input  logic [aop_pkg::SAMPLE_BITS-1:0]      sample_90deg,
    input  logic [aop_pkg::SAMPLE_BITS-1:0]      sample_135deg,
    output logic                                 out_valid,
    output logic signed [aop_pkg::XY_BITS-1:0]   out_x,
    output logic signed [aop_pkg::XY_BITS-1:0]   out_y,
    output aop_pkg::aop_side_t                   out_side
);

    logic [aop_pkg::DIFF_BITS-1:0] d1;
    logic [aop_pkg::DIFF_BITS-1:0] d2;
    logic [aop_pkg::DIFF_BITS-1:0] d1_abs;
    logic [aop_pkg::DIFF_BITS-1:0] d2_abs;
    aop_pkg::aop_side_t            side_next;

    logic                          a_valid_reg;
    logic [aop_pkg::MAG_BITS-1:0]  a_mag_reg;
    logic [aop_pkg::MAG_BITS-1:0]  b_mag_reg;
    aop_pkg::aop_side_t            a_side_reg;

    logic [aop_pkg::MAG_BITS-1:0]   mx;
    logic [aop_pkg::MSB_BITS-1:0]   msb;
    logic [aop_pkg::SHIFT_BITS-1:0] shift_amt;
    logic [aop_pkg::NORM_BITS-1:0]  a_norm;
    logic [aop_pkg::NORM_BITS-1:0]  b_norm;

    logic                           b_valid_reg;
    logic signed [aop_pkg::XY_BITS-1:0] x_reg;
    logic signed [aop_pkg::XY_BITS-1:0] y_reg;
    aop_pkg::aop_side_t             b_side_reg;

    // differences, signs and magnitudes
    always_comb begin
        d1 = {1'b0, sample_0deg} - {1'b0, sample_90deg};
        d2 = {1'b0, sample_45deg} - {1'b0, sample_135deg};
        d1_abs = d1[aop_pkg::DIFF_BITS-1] ? (~d1 + 1'b1) : d1;
        d2_abs = d2[aop_pkg::DIFF_BITS-1] ? (~d2 + 1'b1) : d2;
        side_next.s1_zero = (d1 == '0);
        side_next.s1_neg  = d1[aop_pkg::DIFF_BITS-1];
        side_next.s2_zero = (d2 == '0);
        side_next.s2_neg  = d2[aop_pkg::DIFF_BITS-1];
    end

    // leading one of the larger magnitude and the shift that normalizes it
    always_comb begin
        mx  = (a_mag_reg > b_mag_reg) ? a_mag_reg : b_mag_reg;
        msb = '0;
        for (int k = 0; k < aop_pkg::MAG_BITS; k++) begin
            if (mx[k]) begin
                msb = aop_pkg::MSB_BITS'(k);
            end
        end
        shift_amt = aop_pkg::SHIFT_BITS'(aop_pkg::NORM_MSB)
                  - aop_pkg::SHIFT_BITS'(msb);
        a_norm = aop_pkg::NORM_BITS'(a_mag_reg) << shift_amt;
        b_norm = aop_pkg::NORM_BITS'(b_mag_reg) << shift_amt;
    end

    // stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    // stage payload
    always_ff @(posedge aclk) begin
        if (en) begin
            a_mag_reg  <= aop_pkg::MAG_BITS'(d1_abs);
            b_mag_reg  <= aop_pkg::MAG_BITS'(d2_abs);
            a_side_reg <= side_next;
            x_reg      <= $signed(aop_pkg::XY_BITS'(a_norm));
            y_reg      <= $signed(aop_pkg::XY_BITS'(b_norm));
            b_side_reg <= a_side_reg;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_side  = b_side_reg;

endmodule

// File: hw/rtl/aop_cordic_cell.sv
// one vectoring micro-rotation of the arctangent chain
module aop_cordic_cell (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   en,
    input  logic [aop_pkg::STEP_IDX_BITS-1:0]      step_idx,
    input  logic                                   in_valid,
    input  logic signed [aop_pkg::XY_BITS-1:0]     in_x,
    input  logic signed [aop_pkg::XY_BITS-1:0]     in_y,
    input  logic signed [aop_pkg::Z_BITS-1:0]      in_z,
    input  aop_pkg::aop_side_t                     in_side,
    output logic                                   out_valid,
    output logic signed [aop_pkg::XY_BITS-1:0]     out_x,
    output logic signed [aop_pkg::XY_BITS-1:0]     out_y,
    output logic signed [aop_pkg::Z_BITS-1:0]      out_z,
    output aop_pkg::aop_side_t                     out_side
);

    logic [aop_pkg::XY_BITS-1:0]        x_mag;
    logic [aop_pkg::XY_BITS-1:0]        y_mag;
    logic [aop_pkg::XY_BITS-1:0]        x_sh;
    logic [aop_pkg::XY_BITS-1:0]        y_sh;
    logic signed [aop_pkg::XY_BITS-1:0] xs;
    logic signed [aop_pkg::XY_BITS-1:0] ys;
    logic signed [aop_pkg::Z_BITS-1:0]  atan_step;
    logic signed [aop_pkg::XY_BITS-1:0] x_next;
    logic signed [aop_pkg::XY_BITS-1:0] y_next;
    logic signed [aop_pkg::Z_BITS-1:0]  z_next;

    logic                               valid_reg;
    logic signed [aop_pkg::XY_BITS-1:0] x_reg;
    logic signed [aop_pkg::XY_BITS-1:0] y_reg;
    logic signed [aop_pkg::Z_BITS-1:0]  z_reg;
    aop_pkg::aop_side_t                 side_reg;

    // shifts that truncate toward zero
    always_comb begin
        x_mag = in_x[aop_pkg::XY_BITS-1] ? (~in_x + 1'b1) : in_x;
        y_mag = in_y[aop_pkg::XY_BITS-1] ? (~in_y + 1'b1) : in_y;
        x_sh  = x_mag >> step_idx;
        y_sh  = y_mag >> step_idx;
        xs    = in_x[aop_pkg::XY_BITS-1] ? $signed(~x_sh + 1'b1) : $signed(x_sh);
        ys    = in_y[aop_pkg::XY_BITS-1] ? $signed(~y_sh + 1'b1) : $signed(y_sh);
        atan_step = $signed(aop_pkg::ATAN_TAB[step_idx]);
    end

    // rotate toward the x axis
    always_comb begin
        if (!in_y[aop_pkg::XY_BITS-1]) begin
            x_next = in_x + ys;
            y_next = in_y - xs;
            z_next = in_z + atan_step;
        end else begin
            x_next = in_x - ys;
            y_next = in_y + xs;
            z_next = in_z - atan_step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg    <= x_next;
            y_reg    <= y_next;
            z_reg    <= z_next;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;
    assign out_side  = side_reg;

endmodule

// File: hw/rtl/aop_back.sv
// back end: degree scaling of the cordic angle and quadrant correction
module aop_back (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic signed [aop_pkg::Z_BITS-1:0]    in_z,
    input  aop_pkg::aop_side_t                   in_side,
    output logic                                 out_valid,
    output logic [aop_pkg::ANGLE_BITS-1:0]       out_angle,
    output logic                                 out_undefined
);

    logic [aop_pkg::Z_BITS-1:0]     phi;
    logic [aop_pkg::Q44_BITS-1:0]   q44;
    logic [aop_pkg::PROD_BITS-1:0]  prod;
    logic [aop_pkg::RPROD_BITS-1:0] rprod;
    logic [aop_pkg::ANGLE_BITS-1:0] m8;
    logic [aop_pkg::ANGLE_BITS-1:0] angle_next;
    logic                           undef_next;

    logic                           s1_valid_reg;
    logic [aop_pkg::V_BITS-1:0]     v_reg;
    aop_pkg::aop_side_t             s1_side_reg;
    logic                           s2_valid_reg;
    logic [aop_pkg::M_BITS-1:0]     m_reg;
    aop_pkg::aop_side_t             s2_side_reg;
    logic                           s3_valid_reg;
    logic [aop_pkg::ANGLE_BITS-1:0] angle_reg;
    logic                           undef_reg;

    // clamp, truncate to q44 and scale by 28662
    always_comb begin
        phi  = in_z[aop_pkg::Z_BITS-1] ? '0 : in_z;
        q44  = phi[aop_pkg::Z_BITS-2:aop_pkg::Q44_SHIFT];
        prod = aop_pkg::PROD_BITS'(q44) * aop_pkg::PROD_BITS'(aop_pkg::SCALE_NUM);
    end

    // divide by 1000 through the reciprocal
    assign rprod = aop_pkg::RPROD_BITS'(v_reg) * aop_pkg::RPROD_BITS'(aop_pkg::RECIP_1000);

    // quadrant correction and special cases
    always_comb begin
        m8         = aop_pkg::ANGLE_BITS'(m_reg);
        undef_next = 1'b0;
        if (s2_side_reg.s1_zero && s2_side_reg.s2_zero) begin
            angle_next = aop_pkg::ANG_UNDEF;
            undef_next = 1'b1;
        end else if (s2_side_reg.s1_zero) begin
            angle_next = s2_side_reg.s2_neg ? aop_pkg::ANG_VERT_NEG : aop_pkg::ANG_VERT_POS;
        end else if (s2_side_reg.s2_zero) begin
            angle_next = s2_side_reg.s1_neg ? aop_pkg::ANG_HORIZ_NEG : aop_pkg::ANG_HORIZ_POS;
        end else begin
            case ({s2_side_reg.s1_neg, s2_side_reg.s2_neg})
                2'b00:   angle_next = m8;
                2'b01:   angle_next = aop_pkg::ANG_FOURTH_BASE - m8;
                2'b11:   angle_next = aop_pkg::ANG_THIRD_BASE + m8;
                2'b10:   angle_next = aop_pkg::ANG_SECOND_BASE - m8;
                default: angle_next = m8;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            v_reg       <= prod[aop_pkg::PROD_BITS-1:aop_pkg::PROD_SHIFT];
            s1_side_reg <= in_side;
            m_reg       <= rprod[aop_pkg::RPROD_BITS-1:aop_pkg::RECIP_SHIFT];
            s2_side_reg <= s1_side_reg;
            angle_reg   <= angle_next;
            undef_reg   <= undef_next;
        end
    end

    assign out_valid     = s3_valid_reg;
    assign out_angle     = angle_reg;
    assign out_undefined = undef_reg;

endmodule

// File: hw/rtl/angle_of_polarization_top.sv
// angle of linear polarization: front end, cordic cell chain, scaling and output buffer
//
//   beat      direction  ports
//   samples   in         s_valid s_ready s_sample_0deg s_sample_45deg s_sample_90deg
//                        s_sample_135deg
//   angle     out        m_valid m_ready m_angle_deg m_angle_undefined
//
// one beat per cycle sustained while the skid buffer is free
// the pipeline is the chain of 58 cordic cells, one micro-rotation per cell,
// plus two front stages, three scaling stages and the output register
// synchronous active-low reset clears every valid bit; the datapath is not reset
// a held output parks the next result in a one-beat skid buffer; while that buffer
// is full the whole pipeline freezes and s_ready is low
module angle_of_polarization_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [aop_pkg::SAMPLE_BITS-1:0]   s_sample_0deg,
    input  logic [aop_pkg::SAMPLE_BITS-1:0]   s_sample_45deg,
    input  logic [aop_pkg::SAMPLE_BITS-1:0]   s_sample_90deg,
    input  logic [aop_pkg::SAMPLE_BITS-1:0]   s_sample_135deg,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [aop_pkg::ANGLE_BITS-1:0]    m_angle_deg,
    output logic                              m_angle_undefined
);

    logic en;

    logic                               chain_valid [aop_pkg::CORDIC_STEPS+1];
    logic signed [aop_pkg::XY_BITS-1:0] chain_x     [aop_pkg::CORDIC_STEPS+1];
    logic signed [aop_pkg::XY_BITS-1:0] chain_y     [aop_pkg::CORDIC_STEPS+1];
    logic signed [aop_pkg::Z_BITS-1:0]  chain_z     [aop_pkg::CORDIC_STEPS+1];
    aop_pkg::aop_side_t                 chain_side  [aop_pkg::CORDIC_STEPS+1];

    logic                           fin_valid;
    logic [aop_pkg::ANGLE_BITS-1:0] fin_angle;
    logic                           fin_undef;

    logic                           m_valid_reg;
    logic                           m_valid_next;
    logic [aop_pkg::ANGLE_BITS-1:0] m_angle_reg;
    logic [aop_pkg::ANGLE_BITS-1:0] m_angle_next;
    logic                           m_undef_reg;
    logic                           m_undef_next;
    logic                           skid_full_reg;
    logic                           skid_full_next;
    logic [aop_pkg::ANGLE_BITS-1:0] skid_angle_reg;
    logic [aop_pkg::ANGLE_BITS-1:0] skid_angle_next;
    logic                           skid_undef_reg;
    logic                           skid_undef_next;

    // pipeline advances whenever the skid buffer is free
    assign en      = !skid_full_reg;
    assign s_ready = en;

    // differences and normalization
    aop_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (en),
        .in_valid      (s_valid),
        .sample_0deg   (s_sample_0deg),
        .sample_45deg  (s_sample_45deg),
        .sample_90deg  (s_sample_90deg),
        .sample_135deg (s_sample_135deg),
        .out_valid     (chain_valid[0]),
        .out_x         (chain_x[0]),
        .out_y         (chain_y[0]),
        .out_side      (chain_side[0])
    );

    assign chain_z[0] = '0;

    // cordic cell chain
    for (genvar i = 0; i < aop_pkg::CORDIC_STEPS; i++) begin : g_cell
        aop_cordic_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .step_idx  (aop_pkg::STEP_IDX_BITS'(i)),
            .in_valid  (chain_valid[i]),
            .in_x      (chain_x[i]),
            .in_y      (chain_y[i]),
            .in_z      (chain_z[i]),
            .in_side   (chain_side[i]),
            .out_valid (chain_valid[i+1]),
            .out_x     (chain_x[i+1]),
            .out_y     (chain_y[i+1]),
            .out_z     (chain_z[i+1]),
            .out_side  (chain_side[i+1])
        );
    end

    // scaling and quadrant correction
    aop_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (en),
        .in_valid      (chain_valid[aop_pkg::CORDIC_STEPS]),
        .in_z          (chain_z[aop_pkg::CORDIC_STEPS]),
        .in_side       (chain_side[aop_pkg::CORDIC_STEPS]),
        .out_valid     (fin_valid),
        .out_angle     (fin_angle),
        .out_undefined (fin_undef)
    );

    // output register with one-beat skid buffer
    always_comb begin
        m_valid_next    = m_valid_reg;
        m_angle_next    = m_angle_reg;
        m_undef_next    = m_undef_reg;
        skid_full_next  = skid_full_reg;
        skid_angle_next = skid_angle_reg;
        skid_undef_next = skid_undef_reg;
        if (!m_valid_reg || m_ready) begin
            if (skid_full_reg) begin
                m_valid_next   = 1'b1;
                m_angle_next   = skid_angle_reg;
                m_undef_next   = skid_undef_reg;
                skid_full_next = 1'b0;
            end else begin
                m_valid_next = fin_valid;
                m_angle_next = fin_angle;
                m_undef_next = fin_undef;
            end
        end else if (fin_valid && en) begin
            skid_full_next  = 1'b1;
            skid_angle_next = fin_angle;
            skid_undef_next = fin_undef;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg   <= 1'b0;
            skid_full_reg <= 1'b0;
        end else begin
            m_valid_reg   <= m_valid_next;
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_angle_reg    <= m_angle_next;
        m_undef_reg    <= m_undef_next;
        skid_angle_reg <= skid_angle_next;
        skid_undef_reg <= skid_undef_next;
    end

    assign m_valid           = m_valid_reg;
    assign m_angle_deg       = m_angle_reg;
    assign m_angle_undefined = m_undef_reg;

    // undefined angle is reported as zero
    a_undef_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_angle_undefined |-> m_angle_deg == aop_pkg::ANG_UNDEF)
        else $error("undefined angle with nonzero value");

    // angle stays within a half turn
    a_angle_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_angle_deg <= aop_pkg::ANG_HORIZ_POS)
        else $error("angle above 180 degrees");

    // skid buffer only fills behind a held output beat
    a_skid_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_full_reg) |-> $past(m_valid_reg && !m_ready))
        else $error("skid buffer filled while output was free");

    // a full skid buffer always sits behind a valid output
    a_skid_order: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_full_reg |-> m_valid_reg)
        else $error("skid buffer full with empty output register");

endmodule
